// File: sv/aabb_contact_event_tracker_defines.svh
// Assertion macros for the AABB contact event tracker.
// Needs a clk and a rst signal in the scope where a macro is used.
`ifndef AABB_CONTACT_EVENT_TRACKER_DEFINES_SVH
`define AABB_CONTACT_EVENT_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACET_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACET_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/acet_pkg.sv
// Shared types and constants for the AABB contact event tracker.
// No dependencies.
`default_nettype none

package acet_pkg;

  // Fixed field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned SUM_W   = 17;
  localparam int unsigned EV_W    = 2;

  // Contact event codes
  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_ENTER = 2'd1;
  localparam logic [EV_W-1:0] EV_STAY  = 2'd2;
  localparam logic [EV_W-1:0] EV_EXIT  = 2'd3;

  // Control part of a lookup token moving down the cell chain
  typedef struct packed {
    logic active;  // token carries a pair
    logic touch;   // boxes overlap this beat
    logic done;    // pair found or inserted upstream
    logic prev;    // stored contact flag before this beat
  } tok_ctl_t;

endpackage

`default_nettype wire

// File: sv/acet_ovl.sv
// Front end: forms the pair key and the strict overlap test in two stages.
// Depends on acet_pkg.
`default_nettype none

module acet_ovl #(
  parameter int ID_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    adv,
  input  wire logic                                    in_valid,
  input  wire logic        [acet_pkg::ID_W-1:0]        first_id,
  input  wire logic        [acet_pkg::ID_W-1:0]        second_id,
  input  wire logic signed [acet_pkg::COORD_W-1:0]     first_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0]     first_y,
  input  wire logic        [acet_pkg::SIZE_W-1:0]      first_w,
  input  wire logic        [acet_pkg::SIZE_W-1:0]      first_h,
  input  wire logic signed [acet_pkg::COORD_W-1:0]     second_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0]     second_y,
  input  wire logic        [acet_pkg::SIZE_W-1:0]      second_w,
  input  wire logic        [acet_pkg::SIZE_W-1:0]      second_h,
  output acet_pkg::tok_ctl_t                           ctl,
  output logic             [2*ID_BITS-1:0]             key
);

  localparam int KEY_W = 2 * ID_BITS;
  localparam int DIF_W = acet_pkg::SUM_W;

  logic [ID_BITS-1:0] id_a;
  logic [ID_BITS-1:0] id_b;

  // Fit ids to ID_BITS: drop high bits or zero-extend
  generate
    if (ID_BITS > acet_pkg::ID_W) begin : g_wide
      assign id_a = {{(ID_BITS - acet_pkg::ID_W){1'b0}}, first_id};
      assign id_b = {{(ID_BITS - acet_pkg::ID_W){1'b0}}, second_id};
    end else if (ID_BITS == acet_pkg::ID_W) begin : g_same
      assign id_a = first_id;
      assign id_b = second_id;
    end else begin : g_narrow
      assign id_a = first_id[ID_BITS-1:0];
      assign id_b = second_id[ID_BITS-1:0];
    end
  endgenerate

  // Stage one: differences and size sums
  logic                    v1;
  logic [KEY_W-1:0]        key1;
  logic signed [DIF_W-1:0] dx;
  logic signed [DIF_W-1:0] dy;
  logic [DIF_W-1:0]        sw;
  logic [DIF_W-1:0]        sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key1 <= {id_a, id_b};
      dx   <= DIF_W'(first_x) - DIF_W'(second_x);
      dy   <= DIF_W'(first_y) - DIF_W'(second_y);
      sw   <= DIF_W'(first_w) + DIF_W'(second_w);
      sh   <= DIF_W'(first_h) + DIF_W'(second_h);
    end
  end

  // Stage two: magnitude and strict compare, 2*|d| < sum
  logic [DIF_W-1:0] adx;
  logic [DIF_W-1:0] ady;
  logic             ovl_x;
  logic             ovl_y;

  always_comb begin
    adx   = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
    ady   = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
    ovl_x = {adx, 1'b0} < {1'b0, sw};
    ovl_y = {ady, 1'b0} < {1'b0, sh};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.active <= v1;
      ctl.touch  <= ovl_x & ovl_y;
      ctl.done   <= 1'b0;
      ctl.prev   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key <= key1;
    end
  end

endmodule

`default_nettype wire

// File: sv/acet_cell.sv
// One table entry of the contact tracker: key, in-use bit and contact flag.
// Depends on acet_pkg and the assertion macro header.
`default_nettype none
`include "aabb_contact_event_tracker_defines.svh"

module acet_cell #(
  parameter int KEY_W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire acet_pkg::tok_ctl_t ctl_in,
  input  wire logic [KEY_W-1:0]   key_in,
  output acet_pkg::tok_ctl_t      ctl_out,
  output logic      [KEY_W-1:0]   key_out,
  output logic                    valid
);

  logic [KEY_W-1:0]   entry_key;
  logic               touching;
  logic               live;
  logic               hit;
  logic               grab;
  acet_pkg::tok_ctl_t ctl_next;

  // Match against this entry, or claim it when it is the first free one
  always_comb begin
    live     = ctl_in.active && !ctl_in.done;
    hit      = live && valid && (entry_key == key_in);
    grab     = live && !valid;
    ctl_next = ctl_in;
    if (hit) begin
      ctl_next.done = 1'b1;
      ctl_next.prev = touching;
    end else if (grab) begin
      ctl_next.done = 1'b1;
      ctl_next.prev = 1'b0;
    end
  end

  // Update flags and pass the token on
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      touching <= 1'b0;
      ctl_out  <= '0;
    end else if (adv) begin
      ctl_out <= ctl_next;
      if (grab) begin
        valid <= 1'b1;
      end
      if (hit || grab) begin
        touching <= ctl_in.touch;
      end
    end
  end

  // Store the key on insert, forward the token key
  always_ff @(posedge clk) begin
    if (adv) begin
      key_out <= key_in;
      if (grab) begin
        entry_key <= key_in;
      end
    end
  end

  `ACET_CHECK_NEXT(a_valid_kept, valid, valid, "table entry lost its in-use bit")
  `ACET_CHECK_NOW(a_one_action, 1'b1, !(hit && grab), "cell both hit and inserted")
  `ACET_CHECK_NEXT(a_insert_sets, adv && grab, valid && ctl_out.done,
                   "insert did not resolve the token")

endmodule

`default_nettype wire

// File: sv/aabb_contact_event_tracker.sv
// Top level of the AABB contact event tracker: front end, cell chain, result register.
// Depends on acet_pkg, acet_ovl, acet_cell and the assertion macro header.
//
//   channel  | handshake           | beat contents
//   ---------+---------------------+----------------------------------------------
//   input    | in_valid / in_ready | two ids, two box centers and full sizes
//   result   | out_valid/out_ready | contact_event, table_full
//
// A pair is accepted every cycle unless a result is waiting and out_ready is low.
// Each pair visits one cell per cycle while no result is stalled, passing through two
// front-end stages, the cell chain and the result register.
// A stalled result freezes the whole chain and the front end together.
// Reset clears the in-use and contact flags.
`default_nettype none
`include "aabb_contact_event_tracker_defines.svh"

module aabb_contact_event_tracker #(
  parameter int PAIR_ENTRIES = 64,
  parameter int ID_BITS      = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [acet_pkg::ID_W-1:0]    first_id,
  input  wire logic        [acet_pkg::ID_W-1:0]    second_id,
  input  wire logic signed [acet_pkg::COORD_W-1:0] first_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0] first_y,
  input  wire logic        [acet_pkg::SIZE_W-1:0]  first_w,
  input  wire logic        [acet_pkg::SIZE_W-1:0]  first_h,
  input  wire logic signed [acet_pkg::COORD_W-1:0] second_x,
  input  wire logic signed [acet_pkg::COORD_W-1:0] second_y,
  input  wire logic        [acet_pkg::SIZE_W-1:0]  second_w,
  input  wire logic        [acet_pkg::SIZE_W-1:0]  second_h,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [acet_pkg::EV_W-1:0]    contact_event,
  output logic                                     table_full
);

  localparam int KEY_W = 2 * ID_BITS;

  logic                    adv;
  acet_pkg::tok_ctl_t      ctl_chain [0:PAIR_ENTRIES];
  logic [KEY_W-1:0]        key_chain [0:PAIR_ENTRIES-1];
  logic [PAIR_ENTRIES-1:0] cell_valid;
  acet_pkg::tok_ctl_t      tail;
  logic [acet_pkg::EV_W-1:0] ev_next;

  // Advance everything unless a result is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  acet_ovl #(
    .ID_BITS (ID_BITS)
  ) u_ovl (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .first_id  (first_id),
    .second_id (second_id),
    .first_x   (first_x),
    .first_y   (first_y),
    .first_w   (first_w),
    .first_h   (first_h),
    .second_x  (second_x),
    .second_y  (second_y),
    .second_w  (second_w),
    .second_h  (second_h),
    .ctl       (ctl_chain[0]),
    .key       (key_chain[0])
  );

  // Chain of table entries, lowest index first
  generate
    for (genvar k = 0; k < PAIR_ENTRIES; k++) begin : g_cell
      if (k == PAIR_ENTRIES - 1) begin : g_last
        acet_cell #(
          .KEY_W (KEY_W)
        ) u_cell (
          .clk     (clk),
          .rst     (rst),
          .adv     (adv),
          .ctl_in  (ctl_chain[k]),
          .key_in  (key_chain[k]),
          .ctl_out (ctl_chain[k+1]),
          .key_out (),
          .valid   (cell_valid[k])
        );
      end else begin : g_mid
        acet_cell #(
          .KEY_W (KEY_W)
        ) u_cell (
          .clk     (clk),
          .rst     (rst),
          .adv     (adv),
          .ctl_in  (ctl_chain[k]),
          .key_in  (key_chain[k]),
          .ctl_out (ctl_chain[k+1]),
          .key_out (key_chain[k+1]),
          .valid   (cell_valid[k])
        );
      end
    end
  endgenerate

  // Classify the token leaving the chain
  assign tail = ctl_chain[PAIR_ENTRIES];

  always_comb begin
    case ({tail.touch, tail.done && tail.prev})
      2'b10:   ev_next = acet_pkg::EV_ENTER;
      2'b11:   ev_next = acet_pkg::EV_STAY;
      2'b01:   ev_next = acet_pkg::EV_EXIT;
      default: ev_next = acet_pkg::EV_NONE;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tail.active;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      contact_event <= ev_next;
      table_full    <= !tail.done;
    end
  end

  // Entries fill from the bottom and are never freed
  generate
    for (genvar k = 1; k < PAIR_ENTRIES; k++) begin : g_chk
      `ACET_CHECK_NOW(a_prefix, cell_valid[k], cell_valid[k-1], "in-use bits not a prefix")
    end
  endgenerate

  `ACET_CHECK_NOW(a_full_means_full, out_valid && table_full, &cell_valid,
                  "table_full reported with a free entry")
  `ACET_CHECK_NOW(a_full_event, out_valid && table_full,
                  contact_event == acet_pkg::EV_NONE || contact_event == acet_pkg::EV_ENTER,
                  "untracked pair reported stay or exit")

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for aabb_contact_event_tracker: box pairs in, contact events out.
// Depends on acet_pkg and the tracker RTL; expected events come from a contact table kept here.

module testbench;

  localparam int PAIR_SLOTS = 64;
  localparam int RANDOM_PAIRS = 1800;
  localparam int TABLE_POOL = 48;
  localparam int SPILL_POOL = 4;

  typedef logic        [acet_pkg::ID_W-1:0]    id_t;
  typedef logic signed [acet_pkg::COORD_W-1:0] coord_t;
  typedef logic        [acet_pkg::SIZE_W-1:0]  dim_t;

  typedef struct packed {
    id_t    first_id;
    id_t    second_id;
    coord_t first_x;
    coord_t first_y;
    dim_t   first_w;
    dim_t   first_h;
    coord_t second_x;
    coord_t second_y;
    dim_t   second_w;
    dim_t   second_h;
  } box_pair_t;

  typedef struct packed {
    logic [acet_pkg::EV_W-1:0] contact_event;
    logic                      table_full;
  } contact_result_t;

  // Contact table mirror and queue of events still owed by the block
  class contact_scoreboard;
    logic [2*acet_pkg::ID_W-1:0] pair_key[PAIR_SLOTS];
    bit                          slot_used[PAIR_SLOTS];
    bit                          slot_touch[PAIR_SLOTS];
    contact_result_t             owed_events[$];
    int                          errors;

    function bit table_is_full();
      foreach (slot_used[i]) if (!slot_used[i]) return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return owed_events.size();
    endfunction

    // Look up the pair, test overlap, and queue the event it must produce
    function void note_pair(box_pair_t b);
      logic [2*acet_pkg::ID_W-1:0] key;
      int dx, dy, sum_w, sum_h, hit, free_slot;
      bit touch, prev;
      contact_result_t r;
      key = {b.first_id, b.second_id};
      hit = -1;
      free_slot = -1;
      foreach (slot_used[i]) begin
        if (slot_used[i]) begin
          if (hit < 0 && pair_key[i] == key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      r.table_full = 1'b0;
      if (hit < 0) begin
        if (free_slot >= 0) begin
          hit = free_slot;
          pair_key[hit] = key;
          slot_used[hit] = 1'b1;
          slot_touch[hit] = 1'b0;
        end else begin
          r.table_full = 1'b1;
        end
      end
      prev = (hit >= 0) ? slot_touch[hit] : 1'b0;
      dx = int'(b.first_x) - int'(b.second_x);
      dy = int'(b.first_y) - int'(b.second_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sum_w = int'(b.first_w) + int'(b.second_w);
      sum_h = int'(b.first_h) + int'(b.second_h);
      touch = (2 * dx < sum_w) && (2 * dy < sum_h);
      if (touch) r.contact_event = prev ? acet_pkg::EV_STAY : acet_pkg::EV_ENTER;
      else r.contact_event = prev ? acet_pkg::EV_EXIT : acet_pkg::EV_NONE;
      if (hit >= 0) slot_touch[hit] = touch;
      owed_events.push_back(r);
    endfunction

    // Compare one result beat with the oldest owed event
    function void check_result(logic [acet_pkg::EV_W-1:0] ev, logic full);
      contact_result_t exp_r;
      if (owed_events.size() == 0) begin
        $error("result beat with nothing expected: contact_event=%0d table_full=%0b", ev, full);
        errors++;
        return;
      end
      exp_r = owed_events.pop_front();
      if (ev !== exp_r.contact_event) begin
        $error("contact_event mismatch: expected %0d, actual %0d", exp_r.contact_event, ev);
        errors++;
      end
      if (full !== exp_r.table_full) begin
        $error("table_full mismatch: expected %0b, actual %0b", exp_r.table_full, full);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  id_t                       first_id = '0;
  id_t                       second_id = '0;
  coord_t                    first_x = '0;
  coord_t                    first_y = '0;
  dim_t                      first_w = '0;
  dim_t                      first_h = '0;
  coord_t                    second_x = '0;
  coord_t                    second_y = '0;
  dim_t                      second_w = '0;
  dim_t                      second_h = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [acet_pkg::EV_W-1:0] contact_event;
  logic                      table_full;

  contact_scoreboard sb = new;
  bit calm = 1'b0;
  int stall_left = 0;

  aabb_contact_event_tracker #(
    .PAIR_ENTRIES(PAIR_SLOTS),
    .ID_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_id(first_id),
    .second_id(second_id),
    .first_x(first_x),
    .first_y(first_y),
    .first_w(first_w),
    .first_h(first_h),
    .second_x(second_x),
    .second_y(second_y),
    .second_w(second_w),
    .second_h(second_h),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .contact_event(contact_event),
    .table_full(table_full)
  );

  always #5 clk = ~clk;

  // Note every accepted input beat and check every accepted result beat
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_pair('{first_id, second_id, first_x, first_y, first_w, first_h,
                     second_x, second_y, second_w, second_h});
    if (!rst && out_valid && out_ready)
      sb.check_result(contact_event, table_full);
  end

  // Stall the result side now and then, outside the quiet stretch
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < 2) begin
      stall_left <= $urandom_range(4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic box_pair_t box_pair(
    id_t id_a, id_t id_b,
    int fx, int fy, int fw, int fh, int sx, int sy, int sw, int sh);
    box_pair_t b;
    b.first_id = id_a;
    b.second_id = id_b;
    b.first_x = coord_t'(fx);
    b.first_y = coord_t'(fy);
    b.first_w = dim_t'(fw);
    b.first_h = dim_t'(fh);
    b.second_x = coord_t'(sx);
    b.second_y = coord_t'(sy);
    b.second_w = dim_t'(sw);
    b.second_h = dim_t'(sh);
    return b;
  endfunction

  // Mostly pairs that live in the table, some brand-new ids, and once the
  // table is full a few pairs that can never get an entry
  function automatic box_pair_t random_pair();
    box_pair_t b;
    int pick, k, off_x, off_y;
    pick = $urandom_range(99);
    b.first_id = id_t'($urandom);
    b.second_id = id_t'($urandom);
    if (pick < 80) begin
      k = $urandom_range(TABLE_POOL - 1);
      b.first_id = id_t'(32'h1000 + k);
      b.second_id = id_t'(32'h2000 + 7 * k);
    end else if (pick < 90 && sb.table_is_full()) begin
      k = $urandom_range(SPILL_POOL - 1);
      b.first_id = id_t'(32'hA000 + k);
      b.second_id = id_t'(32'hB000 + k);
    end
    b.first_x = coord_t'($urandom);
    b.first_y = coord_t'($urandom);
    if ($urandom_range(99) < 70) begin
      // Nearby boxes: roughly half of them overlap
      off_x = int'($urandom_range(600)) - 300;
      off_y = int'($urandom_range(600)) - 300;
      b.second_x = coord_t'(int'(b.first_x) + off_x);
      b.second_y = coord_t'(int'(b.first_y) + off_y);
      b.first_w = dim_t'($urandom_range(400));
      b.first_h = dim_t'($urandom_range(400));
      b.second_w = dim_t'($urandom_range(400));
      b.second_h = dim_t'($urandom_range(400));
    end else begin
      b.second_x = coord_t'($urandom);
      b.second_y = coord_t'($urandom);
      b.first_w = dim_t'($urandom);
      b.first_h = dim_t'($urandom);
      b.second_w = dim_t'($urandom);
      b.second_h = dim_t'($urandom);
    end
    return b;
  endfunction

  // Drive one beat, with an occasional idle gap first, and hold it until accepted
  task automatic send_pair(box_pair_t b);
    if (!calm && $urandom_range(99) < 2) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    first_id <= b.first_id;
    second_id <= b.second_id;
    first_x <= b.first_x;
    first_y <= b.first_y;
    first_w <= b.first_w;
    first_h <= b.first_h;
    second_x <= b.second_x;
    second_y <= b.second_y;
    second_w <= b.second_w;
    second_h <= b.second_h;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off the input until every owed event has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Enter, stay, exit, then none on one pair
    send_pair(box_pair(16'h0001, 16'h0002, 0, 0, 16, 16, 0, 0, 16, 16));
    send_pair(box_pair(16'h0001, 16'h0002, 4, -4, 16, 16, 0, 0, 16, 16));
    send_pair(box_pair(16'h0001, 16'h0002, 1000, 0, 16, 16, 0, 0, 16, 16));
    send_pair(box_pair(16'h0001, 16'h0002, 1000, 0, 16, 16, 0, 0, 16, 16));
    // Reversed order is a separate pair
    send_pair(box_pair(16'h0002, 16'h0001, 0, 0, 16, 16, 0, 0, 16, 16));
    // Edges exactly touching do not count, on either axis
    send_pair(box_pair(16'h0003, 16'h0004, 0, 0, 16, 16, 16, 0, 16, 16));
    send_pair(box_pair(16'h0003, 16'h0004, 0, 0, 16, 16, 16, 0, 17, 16));
    send_pair(box_pair(16'h0003, 16'h0004, 0, 0, 16, 16, 0, -16, 16, 16));
    send_pair(box_pair(16'h0003, 16'h0004, 0, 0, 16, 16, 0, -15, 16, 16));
    // A zero size sum never overlaps on that axis; a single zero size can
    send_pair(box_pair(16'h0005, 16'h0006, 0, 0, 0, 16, 0, 0, 0, 16));
    send_pair(box_pair(16'h0005, 16'h0006, 0, 0, 64, 0, 0, 0, 64, 0));
    send_pair(box_pair(16'h0005, 16'h0006, 0, 0, 0, 0, 0, 0, 1, 1));
    // Same id twice and the id extremes
    send_pair(box_pair(16'hFFFF, 16'hFFFF, 5, 5, 8, 8, 5, 5, 8, 8));
    send_pair(box_pair(16'h0000, 16'h0000, 0, 0, 1, 1, 0, 0, 0, 0));
    send_pair(box_pair(16'hFFFF, 16'h0000, 0, 0, 1, 1, 0, 0, 0, 0));
    // Coordinate and size extremes
    send_pair(box_pair(16'h0007, 16'h0008, -32768, -32768, 65535, 65535,
                       32767, 32767, 65535, 65535));
    send_pair(box_pair(16'h0007, 16'h0008, -32768, -32768, 65535, 65535,
                       32766, 32766, 65535, 65535));
    send_pair(box_pair(16'h0007, 16'h0008, 32767, 32767, 65535, 65535,
                       -32767, -32767, 65535, 65535));
    send_pair(box_pair(16'h0007, 16'h0008, 32767, -32768, 0, 65535,
                       -32768, 32767, 65535, 0));
    send_pair(box_pair(16'h0009, 16'h000A, 32767, 32767, 65535, 65535,
                       32767, 32767, 65535, 65535));
    drain();

    // Random traffic, with a quiet stretch and a second full drain midway
    for (n = 0; n < RANDOM_PAIRS; n++) begin
      calm = (n >= 600 && n < 900);
      if (n == 900) drain();
      send_pair(random_pair());
    end
    calm = 1'b0;
    drain();
    repeat (PAIR_SLOTS + 16) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
